// File: design/timed_alert_scheduler_assert.svh
// Assertion macros used by the back module.
`ifndef TIMED_ALERT_SCHEDULER_ASSERT_SVH
`define TIMED_ALERT_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define TAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TAS_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TAS_ASSERT(lbl, clk, rstn, prop, msg)
`define TAS_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: design/tas_pkg.sv
package tas_pkg;

  // Table size default.
  localparam int unsigned TableSlots = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Reciprocal of 1000 scaled by 2^37, for the millisecond to second split.
  localparam logic [27:0] RecipK = 28'd137438954;
  localparam int unsigned RecipShift = 37;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_ACK    = 2'd3
  } mode_e;

  localparam logic [1:0] TONE_NONE   = 2'd0;
  localparam logic [1:0] TONE_NOTICE = 2'd1;
  localparam logic [1:0] TONE_TIME   = 2'd2;
  localparam logic [1:0] TONE_WARN   = 2'd3;

  // One classified word handed from the front to the back.
  typedef struct packed {
    mode_e              mode;
    logic [26:0]        now_ms;
    logic [17:0]        due_s;
    logic [7:0]         prio;
    logic [7:0]         page_id;
    logic [1:0]         tone;
    logic signed [19:0] base;  // offset plus whole seconds of now_ms
    logic signed [19:0] sec;   // tick second, truncated toward zero
    logic [9:0]         rem;   // milliseconds within the second
  } item_t;

  // One stored alert.
  typedef struct packed {
    logic [17:0] due;
    logic [7:0]  prio;
    logic [7:0]  page;
    logic [1:0]  tone;
    logic [15:0] order;
  } entry_t;

  // Lead time of each tone in ms.
  function automatic logic [11:0] lead_ms(input logic [1:0] tone);
    logic [11:0] v;
    case (tone)
      TONE_NOTICE: v = 12'd450;
      TONE_TIME:   v = 12'd3100;
      TONE_WARN:   v = 12'd400;
      default:     v = 12'd0;
    endcase
    return v;
  endfunction

  // Pattern length of each tone in ms.
  function automatic logic [11:0] pattern_len(input logic [1:0] tone);
    logic [11:0] v;
    case (tone)
      TONE_NOTICE: v = 12'd450;
      TONE_TIME:   v = 12'd4000;
      TONE_WARN:   v = 12'd400;
      default:     v = 12'd0;
    endcase
    return v;
  endfunction

  // Buzzer level of a pattern at a given elapsed time.
  function automatic logic pattern_on(input logic [1:0] tone, input logic [27:0] e);
    logic v;
    case (tone)
      TONE_NOTICE: v = (e < 28'd150) || (e >= 28'd300 && e < 28'd450);
      TONE_TIME:   v = (e < 28'd200) || (e >= 28'd1000 && e < 28'd1200) ||
                       (e >= 28'd2000 && e < 28'd2200) || (e >= 28'd3000 && e < 28'd4000);
      TONE_WARN:   v = (e < 28'd400);
      default:     v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

// File: design/timed_alert_scheduler.sv
// Channel  Direction  Handshake               Word
// cfg      in         cfg_valid_i/cfg_ready_o cfg_time_offset_s_i
// in       in         in_valid_i/in_ready_o   mode_i, now_ms_i, due_s_i, prio_i, page_id_i, tone_i
// out      out        out_valid_o/out_ready_i buzzer_o, fired_o, pending_page_o, dropped_o,
//                                             alert_count_o
// The front takes a new word only once the last one is pushed and splits tick time into seconds with two multiplies.
// A tick with no pattern running scans the table to drop stale alerts and pick the best one,
// and scans it again to clear alerts of that due second when one fires; an add searches for
// a free slot and a remove scans the table.
// Reset clears all control state and valid bits at once; no clearing pass is needed.
// A stalled output holds the back, and the queue then fills and holds the front.
module timed_alert_scheduler #(
  parameter int unsigned TABLE_SLOTS = tas_pkg::TableSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [17:0] cfg_time_offset_s_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [26:0] now_ms_i,
  input  logic [17:0] due_s_i,
  input  logic [7:0]  prio_i,
  input  logic [7:0]  page_id_i,
  input  logic [1:0]  tone_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        buzzer_o,
  output logic        fired_o,
  output logic [8:0]  pending_page_o,
  output logic        dropped_o,
  output logic [4:0]  alert_count_o
);

  tas_pkg::item_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop_ready;

  // Front: accepts and classifies words.
  tas_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_time_offset_s_i (cfg_time_offset_s_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .now_ms_i            (now_ms_i),
    .due_s_i             (due_s_i),
    .prio_i              (prio_i),
    .page_id_i           (page_id_i),
    .tone_i              (tone_i),
    .push_valid_o        (push_valid),
    .push_ready_i        (push_ready),
    .push_data_o         (push_data)
  );

  // Queue between front and back.
  tas_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: alert table and buzzer.
  tas_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .buzzer_o       (buzzer_o),
    .fired_o        (fired_o),
    .pending_page_o (pending_page_o),
    .dropped_o      (dropped_o),
    .alert_count_o  (alert_count_o)
  );

endmodule

// File: design/tas_queue.sv
module tas_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tas_pkg::item_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tas_pkg::item_t pop_data_o
);

  localparam int unsigned Depth = tas_pkg::QueueDepth;
  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  tas_pkg::item_t mem_q [Depth];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != CW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Storage for queued words.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// File: design/tas_front.sv
module tas_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [17:0]   cfg_time_offset_s_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    mode_i,
  input  logic [26:0]   now_ms_i,
  input  logic [17:0]   due_s_i,
  input  logic [7:0]    prio_i,
  input  logic [7:0]    page_id_i,
  input  logic [1:0]    tone_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output tas_pkg::item_t push_data_o
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_REM  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e state_q;
  logic signed [17:0] offset_q;
  tas_pkg::item_t item_q;
  logic [17:0] quot_q;
  logic [9:0]  rem_q;
  logic [54:0] recip_prod;
  logic [27:0] thou_prod;
  logic [26:0] rem_full;
  logic signed [19:0] base;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);

  // Seconds and remainder of the tick time.
  assign recip_prod = {28'd0, item_q.now_ms} * {27'd0, tas_pkg::RecipK};
  assign thou_prod  = {10'd0, quot_q} * 28'd1000;
  assign rem_full   = item_q.now_ms - thou_prod[26:0];
  assign base       = {{2{offset_q[17]}}, offset_q} + $signed({2'b00, quot_q});

  // Outgoing word with the derived time fields filled in.
  always_comb begin
    push_data_o      = item_q;
    push_data_o.base = base;
    push_data_o.rem  = rem_q;
    push_data_o.sec  = base + (((base < 0) && (rem_q != '0)) ? 20'sd1 : 20'sd0);
  end

  // Offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_valid_i) begin
      offset_q <= $signed(cfg_time_offset_s_i);
    end
  end

  // Sequencer for one input word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      item_q  <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            item_q.mode    <= tas_pkg::mode_e'(mode_i);
            item_q.now_ms  <= now_ms_i;
            item_q.due_s   <= due_s_i;
            item_q.prio    <= prio_i;
            item_q.page_id <= page_id_i;
            item_q.tone    <= tone_i;
            state_q        <= F_MUL;
          end
        end
        F_MUL: begin
          quot_q  <= recip_prod[tas_pkg::RecipShift +: 18];
          state_q <= F_REM;
        end
        F_REM: begin
          rem_q   <= rem_full[9:0];
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// File: design/tas_back.sv
`include "timed_alert_scheduler_assert.svh"

module tas_back #(
  parameter int unsigned TABLE_SLOTS = tas_pkg::TableSlots
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  tas_pkg::item_t pop_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          buzzer_o,
  output logic          fired_o,
  output logic [8:0]    pending_page_o,
  output logic          dropped_o,
  output logic [4:0]    alert_count_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_SLOTS - 1);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_DISP = 7'b0000010,
    B_SCAN = 7'b0000100,
    B_MUL  = 7'b0001000,
    B_FIRE = 7'b0010000,
    B_ADD  = 7'b0100000,
    B_DONE = 7'b1000000
  } bstate_e;

  typedef enum logic [1:0] {
    K_BEST   = 2'd0,
    K_REMOVE = 2'd1,
    K_CLEAR  = 2'd2
  } kind_e;

  bstate_e state_q;
  kind_e   kind_q;
  tas_pkg::item_t cur_q;

  tas_pkg::entry_t mem_q [TABLE_SLOTS];
  tas_pkg::entry_t rd_q;
  logic [TABLE_SLOTS-1:0] valid_q;
  logic [CW-1:0] count_q;
  logic [15:0] ins_cnt_q;
  logic signed [8:0] held_q;
  logic playing_q;
  logic [1:0] play_tone_q;
  logic [27:0] play_start_q;
  logic buzz_q;
  logic fired_q, dropped_q;

  logic [IW-1:0] scan_idx_q, chk_idx_q;
  logic issue_q, chk_vld_q;

  logic best_found_q;
  logic [17:0] best_due_q;
  logic [7:0]  best_prio_q;
  logic [15:0] best_age_q;
  logic [7:0]  best_page_q;
  logic [1:0]  best_tone_q;
  logic signed [30:0] prod_q;

  logic out_valid_q, out_buzz_q, out_fired_q, out_drop_q;
  logic [8:0] out_page_q;
  logic [4:0] out_count_q;

  logic [27:0] elapsed;
  logic signed [20:0] due_ext, sec_ext, gap_s;
  logic stale, better, hit, scan_end, mem_we;
  logic [15:0] age;
  logic [13:0] rhs;

  assign pop_ready_o    = (state_q == B_IDLE);
  assign out_valid_o    = out_valid_q;
  assign buzzer_o       = out_buzz_q;
  assign fired_o        = out_fired_q;
  assign pending_page_o = out_page_q;
  assign dropped_o      = out_drop_q;
  assign alert_count_o  = out_count_q;

  // Per-slot checks on the entry under the scan.
  always_comb begin
    elapsed = {1'b0, cur_q.now_ms} - play_start_q;
    due_ext = $signed({3'b000, rd_q.due});
    sec_ext = {cur_q.sec[19], cur_q.sec};
    stale   = (due_ext + 21'sd4) < sec_ext;
    age     = ins_cnt_q - rd_q.order;
    better  = !best_found_q || (rd_q.due < best_due_q) ||
              ((rd_q.due == best_due_q) && ((rd_q.prio < best_prio_q) ||
               ((rd_q.prio == best_prio_q) && (age > best_age_q))));
    case (kind_q)
      K_REMOVE: hit = (rd_q.page == cur_q.page_id);
      K_CLEAR:  hit = (rd_q.due == best_due_q);
      default:  hit = stale;
    endcase
    scan_end = chk_vld_q && (chk_idx_q == LastIdx);
    gap_s    = $signed({3'b000, best_due_q}) - {cur_q.base[19], cur_q.base};
    rhs      = 14'd16 + {4'd0, cur_q.rem} + {2'd0, tas_pkg::lead_ms(best_tone_q)};
    mem_we   = (state_q == B_ADD) && !valid_q[scan_idx_q];
  end

  // Alert table storage, one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[scan_idx_q] <= '{due: cur_q.due_s, prio: cur_q.prio, page: cur_q.page_id,
                             tone: cur_q.tone, order: ins_cnt_q};
    end
    rd_q <= mem_q[scan_idx_q];
  end

  // Execution sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      kind_q       <= K_BEST;
      cur_q        <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      ins_cnt_q    <= '0;
      held_q       <= -9'sd1;
      playing_q    <= 1'b0;
      play_tone_q  <= tas_pkg::TONE_NONE;
      play_start_q <= '0;
      buzz_q       <= 1'b0;
      fired_q      <= 1'b0;
      dropped_q    <= 1'b0;
      scan_idx_q   <= '0;
      chk_idx_q    <= '0;
      issue_q      <= 1'b0;
      chk_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      best_due_q   <= '0;
      best_prio_q  <= '0;
      best_age_q   <= '0;
      best_page_q  <= '0;
      best_tone_q  <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_buzz_q   <= 1'b0;
      out_fired_q  <= 1'b0;
      out_drop_q   <= 1'b0;
      out_page_q   <= '0;
      out_count_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != B_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            cur_q     <= pop_data_i;
            fired_q   <= 1'b0;
            dropped_q <= 1'b0;
            state_q   <= B_DISP;
          end
        end
        // Route the word to its operation.
        B_DISP: begin
          scan_idx_q   <= '0;
          issue_q      <= 1'b1;
          chk_vld_q    <= 1'b0;
          best_found_q <= 1'b0;
          case (cur_q.mode)
            tas_pkg::MODE_TICK: begin
              kind_q <= K_BEST;
              if (playing_q && (elapsed < {16'd0, tas_pkg::pattern_len(play_tone_q)})) begin
                buzz_q  <= tas_pkg::pattern_on(play_tone_q, elapsed);
                state_q <= B_DONE;
              end else begin
                if (playing_q) begin
                  playing_q <= 1'b0;
                  buzz_q    <= 1'b0;
                end
                state_q <= B_SCAN;
              end
            end
            tas_pkg::MODE_ADD:    state_q <= B_ADD;
            tas_pkg::MODE_REMOVE: begin
              kind_q  <= K_REMOVE;
              state_q <= B_SCAN;
            end
            default: state_q <= B_DONE;
          endcase
        end
        // One slot read per cycle, checked in the cycle after its read.
        B_SCAN: begin
          if (issue_q) begin
            chk_idx_q <= scan_idx_q;
            chk_vld_q <= 1'b1;
            if (scan_idx_q == LastIdx) begin
              issue_q <= 1'b0;
            end else begin
              scan_idx_q <= scan_idx_q + IW'(1);
            end
          end else begin
            chk_vld_q <= 1'b0;
          end
          if (chk_vld_q && valid_q[chk_idx_q]) begin
            if (hit) begin
              valid_q[chk_idx_q] <= 1'b0;
              count_q            <= count_q - CW'(1);
            end else if (kind_q == K_BEST && better) begin
              best_found_q <= 1'b1;
              best_due_q   <= rd_q.due;
              best_prio_q  <= rd_q.prio;
              best_age_q   <= age;
              best_page_q  <= rd_q.page;
              best_tone_q  <= rd_q.tone;
            end
          end
          if (scan_end) begin
            if (kind_q == K_BEST) begin
              if (best_found_q || (valid_q[chk_idx_q] && !hit)) begin
                state_q <= B_MUL;
              end else begin
                state_q <= B_DONE;
              end
            end else begin
              state_q <= B_DONE;
            end
          end
        end
        B_MUL: begin
          prod_q  <= 31'(gap_s) * 31'sd1000;
          state_q <= B_FIRE;
        end
        // Fire when the remaining wait is under the margin.
        B_FIRE: begin
          if (prod_q < $signed({17'd0, rhs})) begin
            fired_q    <= 1'b1;
            held_q     <= $signed({1'b0, best_page_q});
            kind_q     <= K_CLEAR;
            scan_idx_q <= '0;
            issue_q    <= 1'b1;
            chk_vld_q  <= 1'b0;
            state_q    <= B_SCAN;
            if (best_tone_q != tas_pkg::TONE_NONE) begin
              playing_q    <= 1'b1;
              play_tone_q  <= best_tone_q;
              play_start_q <= {1'b0, cur_q.now_ms};
              buzz_q       <= tas_pkg::pattern_on(best_tone_q, 28'd0);
            end
          end else begin
            state_q <= B_DONE;
          end
        end
        // Search for the lowest free slot, and flag a drop when none is free.
        B_ADD: begin
          if (!valid_q[scan_idx_q]) begin
            valid_q[scan_idx_q] <= 1'b1;
            count_q             <= count_q + CW'(1);
            ins_cnt_q           <= ins_cnt_q + 16'd1;
            state_q             <= B_DONE;
          end else if (scan_idx_q == LastIdx) begin
            dropped_q <= 1'b1;
            state_q   <= B_DONE;
          end else begin
            scan_idx_q <= scan_idx_q + IW'(1);
          end
        end
        // Hand the result to the output register.
        B_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_buzz_q  <= buzz_q;
            out_fired_q <= fired_q;
            out_drop_q  <= dropped_q;
            out_page_q  <= held_q;
            out_count_q <= 5'(count_q);
            if (cur_q.mode == tas_pkg::MODE_ACK) begin
              held_q <= -9'sd1;
            end
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `TAS_ASSERT(a_count_match, clk_i, rst_ni, $countones(valid_q) == 32'(count_q), "count mismatch")
  `TAS_NEVER(a_fire_drop, clk_i, rst_ni, out_valid_q && out_fired_q && out_drop_q, "fire and drop")
  `TAS_NEVER(a_play_tone, clk_i, rst_ni, playing_q && (play_tone_q == tas_pkg::TONE_NONE), "silent play")
  `TAS_ASSERT(a_add_grows, clk_i, rst_ni, (state_q == B_ADD) && !valid_q[scan_idx_q] |=> count_q == $past(count_q) + CW'(1), "add count")

endmodule
